// ===== sv/sfk_pkg.sv =====
package sfk_pkg;

  localparam int JOINT_COUNT = 24;
  localparam int QUAT_FRAC   = 14;
  localparam int POS_FRAC    = 16;

  localparam int ACC_W = 54;
  localparam int SH_W  = 40;
  localparam int UV_W  = 36;
  localparam int UUV_W = 39;
  localparam int PRD_W = 16 + UV_W;
  localparam int SUM_W = 44;

  localparam logic [4:0] LAST_JOINT = 5'(JOINT_COUNT - 1);
  localparam logic [4:0] LAST_STEP  = 5'd30;

  typedef logic signed [31:0] pos_t;
  typedef logic [2:0][31:0]   vec3_t;
  typedef logic [3:0][15:0]   quat_t;

  typedef enum logic [1:0] {
    B_Q   = 2'd0,
    B_OFS = 2'd1,
    B_UV  = 2'd2
  } bsel_e;

  typedef enum logic [1:0] {
    D_ROT = 2'd0,
    D_UV  = 2'd1,
    D_UUV = 2'd2,
    D_POS = 2'd3
  } dest_e;

  typedef struct packed {
    logic [1:0] a_idx;
    bsel_e      bsel;
    logic [1:0] b_idx;
    logic       neg;
    logic       first;
    logic       last;
    dest_e      dest;
    logic [1:0] d_idx;
  } uop_t;

  function automatic uop_t mk_uop(input logic [1:0] a, input bsel_e bs, input logic [1:0] b,
                                  input logic ng, input logic fs, input logic ls,
                                  input dest_e d, input logic [1:0] di);
    uop_t u;
    u.a_idx = a;
    u.bsel  = bs;
    u.b_idx = b;
    u.neg   = ng;
    u.first = fs;
    u.last  = ls;
    u.dest  = d;
    u.d_idx = di;
    return u;
  endfunction

  // one product per step, a always a component of the parent world rotation
  function automatic uop_t ucode(input logic [4:0] s);
    uop_t u;
    u = mk_uop(2'd0, B_Q, 2'd0, 1'b0, 1'b0, 1'b0, D_ROT, 2'd0);
    unique case (s)
      5'd0:  u = mk_uop(2'd0, B_Q,   2'd0, 1'b0, 1'b1, 1'b0, D_ROT, 2'd0);
      5'd1:  u = mk_uop(2'd1, B_Q,   2'd1, 1'b1, 1'b0, 1'b0, D_ROT, 2'd0);
      5'd2:  u = mk_uop(2'd2, B_Q,   2'd2, 1'b1, 1'b0, 1'b0, D_ROT, 2'd0);
      5'd3:  u = mk_uop(2'd3, B_Q,   2'd3, 1'b1, 1'b0, 1'b1, D_ROT, 2'd0);
      5'd4:  u = mk_uop(2'd0, B_Q,   2'd1, 1'b0, 1'b1, 1'b0, D_ROT, 2'd1);
      5'd5:  u = mk_uop(2'd1, B_Q,   2'd0, 1'b0, 1'b0, 1'b0, D_ROT, 2'd1);
      5'd6:  u = mk_uop(2'd2, B_Q,   2'd3, 1'b0, 1'b0, 1'b0, D_ROT, 2'd1);
      5'd7:  u = mk_uop(2'd3, B_Q,   2'd2, 1'b1, 1'b0, 1'b1, D_ROT, 2'd1);
      5'd8:  u = mk_uop(2'd0, B_Q,   2'd2, 1'b0, 1'b1, 1'b0, D_ROT, 2'd2);
      5'd9:  u = mk_uop(2'd1, B_Q,   2'd3, 1'b1, 1'b0, 1'b0, D_ROT, 2'd2);
      5'd10: u = mk_uop(2'd2, B_Q,   2'd0, 1'b0, 1'b0, 1'b0, D_ROT, 2'd2);
      5'd11: u = mk_uop(2'd3, B_Q,   2'd1, 1'b0, 1'b0, 1'b1, D_ROT, 2'd2);
      5'd12: u = mk_uop(2'd0, B_Q,   2'd3, 1'b0, 1'b1, 1'b0, D_ROT, 2'd3);
      5'd13: u = mk_uop(2'd1, B_Q,   2'd2, 1'b0, 1'b0, 1'b0, D_ROT, 2'd3);
      5'd14: u = mk_uop(2'd2, B_Q,   2'd1, 1'b1, 1'b0, 1'b0, D_ROT, 2'd3);
      5'd15: u = mk_uop(2'd3, B_Q,   2'd0, 1'b0, 1'b0, 1'b1, D_ROT, 2'd3);
      5'd16: u = mk_uop(2'd2, B_OFS, 2'd2, 1'b0, 1'b1, 1'b0, D_UV,  2'd0);
      5'd17: u = mk_uop(2'd3, B_OFS, 2'd1, 1'b1, 1'b0, 1'b1, D_UV,  2'd0);
      5'd18: u = mk_uop(2'd3, B_OFS, 2'd0, 1'b0, 1'b1, 1'b0, D_UV,  2'd1);
      5'd19: u = mk_uop(2'd1, B_OFS, 2'd2, 1'b1, 1'b0, 1'b1, D_UV,  2'd1);
      5'd20: u = mk_uop(2'd1, B_OFS, 2'd1, 1'b0, 1'b1, 1'b0, D_UV,  2'd2);
      5'd21: u = mk_uop(2'd2, B_OFS, 2'd0, 1'b1, 1'b0, 1'b1, D_UV,  2'd2);
      // uuv z first so uv z has landed before it is read
      5'd22: u = mk_uop(2'd1, B_UV,  2'd1, 1'b0, 1'b1, 1'b0, D_UUV, 2'd2);
      5'd23: u = mk_uop(2'd2, B_UV,  2'd0, 1'b1, 1'b0, 1'b1, D_UUV, 2'd2);
      5'd24: u = mk_uop(2'd2, B_UV,  2'd2, 1'b0, 1'b1, 1'b0, D_UUV, 2'd0);
      5'd25: u = mk_uop(2'd3, B_UV,  2'd1, 1'b1, 1'b0, 1'b1, D_UUV, 2'd0);
      5'd26: u = mk_uop(2'd3, B_UV,  2'd0, 1'b0, 1'b1, 1'b0, D_UUV, 2'd1);
      5'd27: u = mk_uop(2'd1, B_UV,  2'd2, 1'b1, 1'b0, 1'b1, D_UUV, 2'd1);
      5'd28: u = mk_uop(2'd0, B_UV,  2'd0, 1'b0, 1'b1, 1'b1, D_POS, 2'd0);
      5'd29: u = mk_uop(2'd0, B_UV,  2'd1, 1'b0, 1'b1, 1'b1, D_POS, 2'd1);
      5'd30: u = mk_uop(2'd0, B_UV,  2'd2, 1'b0, 1'b1, 1'b1, D_POS, 2'd2);
      default: u = mk_uop(2'd0, B_Q, 2'd0, 1'b0, 1'b0, 1'b0, D_ROT, 2'd0);
    endcase
    return u;
  endfunction

  function automatic logic [4:0] parent_rom(input logic [4:0] j);
    logic [4:0] p;
    unique case (j)
      5'd0, 5'd1, 5'd2, 5'd3: p = 5'd0;
      5'd4:  p = 5'd1;
      5'd5:  p = 5'd2;
      5'd6:  p = 5'd3;
      5'd7:  p = 5'd4;
      5'd8:  p = 5'd5;
      5'd9:  p = 5'd6;
      5'd10: p = 5'd7;
      5'd11: p = 5'd8;
      5'd12, 5'd13, 5'd14: p = 5'd9;
      5'd15: p = 5'd12;
      5'd16: p = 5'd13;
      5'd17: p = 5'd14;
      5'd18: p = 5'd16;
      5'd19: p = 5'd17;
      5'd20: p = 5'd18;
      5'd21: p = 5'd19;
      5'd22: p = 5'd20;
      5'd23: p = 5'd21;
      default: p = 5'd0;
    endcase
    return p;
  endfunction

  function automatic vec3_t mk3(input int x, input int y, input int z);
    vec3_t v;
    v[0] = 32'(x);
    v[1] = 32'(y);
    v[2] = 32'(z);
    return v;
  endfunction

  // rest offsets in Q16.16, mm * 65.536 rounded half away from zero
  function automatic vec3_t ofs_rom(input logic [4:0] j);
    vec3_t v;
    unique case (j)
      5'd1:  v = mk3(3801, -5374, 918);
      5'd2:  v = mk3(-3932, -5898, 852);
      5'd3:  v = mk3(328, 8126, -2490);
      5'd4:  v = mk3(2556, -25625, -721);
      5'd5:  v = mk3(-2556, -26477, -852);
      5'd6:  v = mk3(-262, 9110, 1704);
      5'd7:  v = mk3(-1835, -27394, -2556);
      5'd8:  v = mk3(1966, -27591, -2556);
      5'd9:  v = mk3(-262, 3604, 328);
      5'd10: v = mk3(1901, -4194, 8520);
      5'd11: v = mk3(-1966, -3998, 8585);
      5'd12: v = mk3(721, 14352, -2556);
      5'd13: v = mk3(-4653, 7471, -1180);
      5'd14: v = mk3(5439, 7471, -1442);
      5'd15: v = mk3(66, 5833, 3277);
      5'd16: v = mk3(7930, 3015, -524);
      5'd17: v = mk3(-7471, 3080, -655);
      5'd18: v = mk3(16712, -983, -1442);
      5'd19: v = mk3(-17039, -852, -1442);
      5'd20: v = mk3(17367, 721, -459);
      5'd21: v = mk3(-17629, 459, -393);
      5'd22: v = mk3(5702, -655, -1180);
      5'd23: v = mk3(-5833, -459, -1180);
      default: v = mk3(0, 0, 0);
    endcase
    return v;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [SH_W-1:0] v);
    logic [15:0] r;
    if (v > 40'sd32767) r = 16'h7fff;
    else if (v < -40'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [31:0] r;
    if (v > 44'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -44'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== sv/skeleton_forward_kinematics.sv =====
// Forward kinematics over a fixed 24-joint skeleton. Feed one word per joint, joints 0 to 23 in
// order, each with that joint's local rotation (Q2.14) and the root translation (Q16.16, used on
// joint 0 only); the block returns one word per joint with the world rotation and world position
// (both saturated), the joint number and a flag on joint 23. Parent links and rest offsets are a
// fixed ROM. World rotation and position of each joint sit in two 24-entry synchronous memories,
// read at the parent's entry and written back at the joint's own entry. The root joint goes from
// accept straight to writeback; every other joint steps through accept, which also reads the
// parent from memory, 31 products through a single 16x36 multiplier with an accumulator behind it,
// a drain state and a writeback state. The writeback state stretches while the previous result
// still waits in the output register. The output register lets the next word be accepted while
// a result waits.
module skeleton_forward_kinematics (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] rot_w_i,
  input  logic [15:0] rot_x_i,
  input  logic [15:0] rot_y_i,
  input  logic [15:0] rot_z_i,
  input  logic [31:0] root_x_i,
  input  logic [31:0] root_y_i,
  input  logic [31:0] root_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  joint_number_o,
  output logic [15:0] world_w_o,
  output logic [15:0] world_x_o,
  output logic [15:0] world_y_o,
  output logic [15:0] world_z_o,
  output logic [31:0] pos_x_o,
  output logic [31:0] pos_y_o,
  output logic [31:0] pos_z_o,
  output logic        last_joint_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [4:0] step_q, step_d;
  logic out_valid_q, out_valid_d;

  // latched input word
  sfk_pkg::quat_t q_q;

  // world state memories and their registered read ports
  sfk_pkg::quat_t rot_mem [sfk_pkg::JOINT_COUNT];
  sfk_pkg::vec3_t pos_mem [sfk_pkg::JOINT_COUNT];
  sfk_pkg::quat_t rot_rd_q;
  sfk_pkg::vec3_t pos_rd_q;

  // datapath
  logic signed [sfk_pkg::PRD_W-1:0] prod_q;
  sfk_pkg::uop_t uc_q, uc_cur;
  logic p1_vld_q;
  logic signed [sfk_pkg::ACC_W-1:0] acc_q, acc_d, acc_base, prod_ext;
  logic signed [sfk_pkg::ACC_W-1:0] acc_sh;
  logic signed [sfk_pkg::SH_W-1:0]  sh;
  logic signed [sfk_pkg::UV_W-1:0]  uv_q  [3];
  logic signed [sfk_pkg::UUV_W-1:0] uuv_q [3];
  logic signed [15:0]               a_sel;
  logic signed [sfk_pkg::UV_W-1:0]  b_sel;
  logic signed [sfk_pkg::SH_W:0]    t_sum;
  logic signed [sfk_pkg::SUM_W-1:0] pos_sum;
  sfk_pkg::vec3_t ofs;

  // result holding and output registers
  sfk_pkg::quat_t res_rot_q;
  sfk_pkg::vec3_t res_pos_q;
  sfk_pkg::quat_t out_rot_q;
  sfk_pkg::vec3_t out_pos_q;
  logic [4:0] out_j_q;
  logic out_last_q;

  logic in_acc, issue, fin_load, mem_rd_en;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign issue      = (state_q == ST_CALC);
  assign fin_load   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign mem_rd_en  = (state_q == ST_IDLE);
  assign ofs        = sfk_pkg::ofs_rom(cnt_q);
  assign uc_cur     = sfk_pkg::ucode(step_q);

  // control sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        step_d = 5'd0;
        if (in_acc) begin
          // root joint needs no products
          state_d = (cnt_q == 5'd0) ? ST_FIN : ST_CALC;
        end
      end
      ST_CALC: begin
        step_d = step_q + 5'd1;
        if (step_q == sfk_pkg::LAST_STEP) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          cnt_d       = (cnt_q == sfk_pkg::LAST_JOINT) ? 5'd0 : cnt_q + 5'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 5'd0;
      cnt_q       <= 5'd0;
      out_valid_q <= 1'b0;
      p1_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      p1_vld_q    <= issue;
    end
  end

  // memories: read the parent while idle, write the finished joint back
  always_ff @(posedge clk_i) begin
    if (mem_rd_en) begin
      rot_rd_q <= rot_mem[sfk_pkg::parent_rom(cnt_q)];
      pos_rd_q <= pos_mem[sfk_pkg::parent_rom(cnt_q)];
    end
    if (fin_load) begin
      rot_mem[cnt_q] <= res_rot_q;
      pos_mem[cnt_q] <= res_pos_q;
    end
  end

  // multiplier operand select
  always_comb begin
    a_sel = $signed(rot_rd_q[uc_cur.a_idx]);
    unique case (uc_cur.bsel)
      sfk_pkg::B_Q:   b_sel = sfk_pkg::UV_W'($signed(q_q[uc_cur.b_idx]));
      sfk_pkg::B_OFS: b_sel = sfk_pkg::UV_W'($signed(ofs[uc_cur.b_idx]));
      sfk_pkg::B_UV:  b_sel = uv_q[uc_cur.b_idx];
      default:        b_sel = '0;
    endcase
  end

  // accumulate stage, arithmetic shift right truncates toward minus infinity
  always_comb begin
    prod_ext = sfk_pkg::ACC_W'(prod_q);
    acc_base = uc_q.first ? '0 : acc_q;
    acc_d    = uc_q.neg ? (acc_base - prod_ext) : (acc_base + prod_ext);
    acc_sh   = acc_d >>> sfk_pkg::QUAT_FRAC;
    sh       = acc_sh[sfk_pkg::SH_W-1:0];
    // parent pos + offset + 2*(w*(u x v) + u x (u x v))
    t_sum    = (sfk_pkg::SH_W+1)'(sh) + (sfk_pkg::SH_W+1)'(uuv_q[uc_q.d_idx]);
    pos_sum  = sfk_pkg::SUM_W'($signed(pos_rd_q[uc_q.d_idx]))
             + sfk_pkg::SUM_W'($signed(ofs[uc_q.d_idx]))
             + sfk_pkg::SUM_W'($signed({t_sum, 1'b0}));
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      q_q          <= {rot_z_i, rot_y_i, rot_x_i, rot_w_i};
      res_rot_q    <= {rot_z_i, rot_y_i, rot_x_i, rot_w_i};
      res_pos_q[0] <= sfk_pkg::sat32(sfk_pkg::SUM_W'($signed(root_x_i))
                                     + sfk_pkg::SUM_W'($signed(ofs[0])));
      res_pos_q[1] <= sfk_pkg::sat32(sfk_pkg::SUM_W'($signed(root_y_i))
                                     + sfk_pkg::SUM_W'($signed(ofs[1])));
      res_pos_q[2] <= sfk_pkg::sat32(sfk_pkg::SUM_W'($signed(root_z_i))
                                     + sfk_pkg::SUM_W'($signed(ofs[2])));
    end
    if (issue) begin
      prod_q <= a_sel * b_sel;
      uc_q   <= uc_cur;
    end
    if (p1_vld_q) begin
      acc_q <= acc_d;
      if (uc_q.last) begin
        unique case (uc_q.dest)
          sfk_pkg::D_ROT: res_rot_q[uc_q.d_idx] <= sfk_pkg::sat16(sh);
          sfk_pkg::D_UV:  uv_q[uc_q.d_idx]      <= sh[sfk_pkg::UV_W-1:0];
          sfk_pkg::D_UUV: uuv_q[uc_q.d_idx]     <= sh[sfk_pkg::UUV_W-1:0];
          sfk_pkg::D_POS: res_pos_q[uc_q.d_idx] <= sfk_pkg::sat32(pos_sum);
          default: ;
        endcase
      end
    end
    if (fin_load) begin
      out_rot_q  <= res_rot_q;
      out_pos_q  <= res_pos_q;
      out_j_q    <= cnt_q;
      out_last_q <= (cnt_q == sfk_pkg::LAST_JOINT);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign joint_number_o = out_j_q;
  assign world_w_o      = out_rot_q[0];
  assign world_x_o      = out_rot_q[1];
  assign world_y_o      = out_rot_q[2];
  assign world_z_o      = out_rot_q[3];
  assign pos_x_o        = out_pos_q[0];
  assign pos_y_o        = out_pos_q[1];
  assign pos_z_o        = out_pos_q[2];
  assign last_joint_o   = out_last_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o) else $error("accepted a word while busy");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |-> step_q <= sfk_pkg::LAST_STEP) else $error("step overrun");
  a_pipe_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_vld_q |-> (state_q == ST_CALC || state_q == ST_DRAIN))
    else $error("product pending outside calc");
  a_drain_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |=> state_q == ST_FIN) else $error("drain did not finish");
  a_pose_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load && cnt_q == sfk_pkg::LAST_JOINT |=> cnt_q == 5'd0)
    else $error("joint counter did not wrap");
`endif

endmodule
